[src/drm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damage rectangle merger package
// Shared types, codes and constants for the merger core and its parts.
// ----------------------------------------------------------------------------
package drm_pkg;

   localparam int DEF_MAX_RECTS = 16;
   localparam int COORD_W       = 16;

   typedef enum logic [1:0] {
      ACT_ADD_SCREEN = 2'd0,
      ACT_ADD_WINDOW = 2'd1,
      ACT_RESET_LIST = 2'd2,
      ACT_MARK_ALL   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_FULL  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // classified request handed from the front to the back
   typedef struct packed {
      op_type            op;
      logic              status;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
   } box_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FOLD_RD,
      ST_FOLD_CHK,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_APPEND,
      ST_DUMP_RD,
      ST_DUMP_OUT,
      ST_DUMP_EMPTY
   } state_type;

   function automatic logic boxes_touch(box_type a, box_type b);
      logic [COORD_W:0] ar, ab, br, bb;
      ar = {1'b0, a.x} + {1'b0, a.w};
      ab = {1'b0, a.y} + {1'b0, a.h};
      br = {1'b0, b.x} + {1'b0, b.w};
      bb = {1'b0, b.y} + {1'b0, b.h};
      return ({1'b0, a.x} <= br) && ({1'b0, b.x} <= ar) &&
             ({1'b0, a.y} <= bb) && ({1'b0, b.y} <= ab);
   endfunction

   function automatic box_type box_union(box_type a, box_type b);
      logic [COORD_W:0] ar, ab, br, bb, r, bt;
      box_type u;
      ar = {1'b0, a.x} + {1'b0, a.w};
      ab = {1'b0, a.y} + {1'b0, a.h};
      br = {1'b0, b.x} + {1'b0, b.w};
      bb = {1'b0, b.y} + {1'b0, b.h};
      r  = (ar > br) ? ar : br;
      bt = (ab > bb) ? ab : bb;
      u.x = (a.x < b.x) ? a.x : b.x;
      u.y = (a.y < b.y) ? a.y : b.y;
      u.w = COORD_W'(r - {1'b0, u.x});
      u.h = COORD_W'(bt - {1'b0, u.y});
      return u;
   endfunction

endpackage

[src/drm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[src/drm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merger front end
// Clips requests to window and screen and classifies them into commands.
// ----------------------------------------------------------------------------
module drm_front
   import drm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_action,
   input  logic signed [16:0]  req_rect_x,
   input  logic signed [16:0]  req_rect_y,
   input  logic signed [17:0]  req_rect_width,
   input  logic signed [17:0]  req_rect_height,
   input  logic                req_window_active,
   input  logic signed [16:0]  req_window_x,
   input  logic signed [16:0]  req_window_y,
   input  logic [15:0]         req_window_width,
   input  logic [15:0]         req_window_height,
   input  logic [15:0]         disp_w,
   input  logic [15:0]         disp_h,
   output logic                cmd_valid,
   output cmd_type             cmd,
   input  logic                cmd_take
);

   // stage 1: window clip and offset; stage 2: screen clip
   logic               s1_valid_ff, s1_valid_in;
   logic [1:0]         s1_act_ff;
   logic               s1_bad_ff, s1_none_ff;
   logic signed [19:0] s1_l_ff, s1_t_ff, s1_r_ff, s1_b_ff;
   logic               q_valid_ff, q_valid_in;
   cmd_type            q_ff, q_in;

   logic signed [19:0] l0, t0, r0, b0, l1, t1, r1, b1;
   logic               win_empty, in_empty;
   logic               s1_adv;

   always_comb begin
      l0 = 20'(req_rect_x);
      t0 = 20'(req_rect_y);
      r0 = l0 + 20'(req_rect_width);
      b0 = t0 + 20'(req_rect_height);
      in_empty = (req_rect_width <= 0) || (req_rect_height <= 0);
      l1 = (l0 < 0) ? 20'sd0 : l0;
      t1 = (t0 < 0) ? 20'sd0 : t0;
      r1 = (r0 > $signed({4'd0, req_window_width})) ? $signed({4'd0, req_window_width}) : r0;
      b1 = (b0 > $signed({4'd0, req_window_height})) ? $signed({4'd0, req_window_height})
                                                      : b0;
      win_empty = in_empty || (r1 <= l1) || (b1 <= t1);
   end

   assign s1_adv   = !q_valid_ff || cmd_take;
   assign req_full = s1_valid_ff && !s1_adv;

   assign s1_valid_in = (req_push && !req_full) || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         q_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         q_valid_ff  <= q_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_push && !req_full) begin
         s1_act_ff <= req_action;
         if (action_type'(req_action) == ACT_ADD_WINDOW) begin
            s1_bad_ff  <= !req_window_active;
            s1_none_ff <= !req_window_active || win_empty;
            s1_l_ff <= l1 + 20'(req_window_x);
            s1_t_ff <= t1 + 20'(req_window_y);
            s1_r_ff <= r1 + 20'(req_window_x);
            s1_b_ff <= b1 + 20'(req_window_y);
         end else begin
            s1_bad_ff  <= 1'b0;
            s1_none_ff <= in_empty;
            s1_l_ff <= l0;
            s1_t_ff <= t0;
            s1_r_ff <= r0;
            s1_b_ff <= b0;
         end
      end
      if (s1_valid_ff && s1_adv) begin
         q_ff <= q_in;
      end
   end

   logic signed [19:0] l2, t2, r2, b2, sw, sh;
   logic               scr_zero;

   always_comb begin
      sw = $signed({4'd0, disp_w});
      sh = $signed({4'd0, disp_h});
      scr_zero = (disp_w == 16'd0) || (disp_h == 16'd0);
      l2 = (s1_l_ff < 0) ? 20'sd0 : s1_l_ff;
      t2 = (s1_t_ff < 0) ? 20'sd0 : s1_t_ff;
      r2 = (s1_r_ff > sw) ? sw : s1_r_ff;
      b2 = (s1_b_ff > sh) ? sh : s1_b_ff;
      q_in = '0;
      q_in.op = OP_NONE;
      case (action_type'(s1_act_ff))
         ACT_ADD_SCREEN, ACT_ADD_WINDOW: begin
            if (s1_bad_ff) begin
               q_in.status = 1'b1;
            end else if (s1_act_ff == 2'(ACT_ADD_WINDOW) && s1_none_ff) begin
               q_in.status = 1'b0;
            end else if (scr_zero) begin
               q_in.status = 1'b1;
            end else if (!s1_none_ff && (r2 > l2) && (b2 > t2)) begin
               q_in.op = OP_ADD;
               q_in.x = l2[15:0];
               q_in.y = t2[15:0];
               q_in.w = 16'(r2 - l2);
               q_in.h = 16'(b2 - t2);
            end
         end
         ACT_RESET_LIST: q_in.op = OP_CLEAR;
         ACT_MARK_ALL: q_in.op = OP_FULL;
         default: q_in.op = OP_NONE;
      endcase
   end

   assign q_valid_in = (s1_valid_ff && s1_adv) || (q_valid_ff && !cmd_take);
   assign cmd_valid  = q_valid_ff;
   assign cmd        = q_ff;

endmodule

[src/drm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merger back end
// Walks the rectangle list in RAM, merges, and dumps the list as responses.
// ----------------------------------------------------------------------------
module drm_back
   import drm_pkg::*;
#(
   parameter int MAX_RECTS = DEF_MAX_RECTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] disp_w,
   input  logic [15:0] disp_h,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_take,
   output logic        out_valid,
   input  logic        out_take,
   output logic        o_status,
   output logic        o_all_dirty,
   output logic [4:0]  o_rect_count,
   output logic        o_entry_valid,
   output box_type     o_box,
   output logic        o_last
);

   localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CW = $clog2(MAX_RECTS + 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          full_ff, full_in;
   logic          status_ff, status_in;
   box_type       nbox_ff, nbox_in;
   box_type       acc_ff, acc_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;

   logic          we;
   logic [AW-1:0] wa, ra;
   box_type       wd, rd;

   drm_ram #(.WIDTH($bits(box_type)), .DEPTH(MAX_RECTS)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wa),
      .wr_data (wd),
      .rd_addr (ra),
      .rd_data (rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         full_ff  <= full_in;
      end
      status_ff <= status_in;
      nbox_ff   <= nbox_in;
      acc_ff    <= acc_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
   end

   logic scr_zero;
   box_type scr_box;
   assign scr_zero = (disp_w == 16'd0) || (disp_h == 16'd0);
   assign scr_box  = '{x: 16'd0, y: 16'd0, w: disp_w, h: disp_h};

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      full_in   = full_ff;
      status_in = status_ff;
      nbox_in   = nbox_ff;
      acc_in    = acc_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      we        = 1'b0;
      wa        = '0;
      wd        = acc_ff;
      ra        = AW'(i_ff);
      cmd_take  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take  = 1'b1;
               status_in = cmd.status;
               nbox_in   = '{x: cmd.x, y: cmd.y, w: cmd.w, h: cmd.h};
               i_in      = '0;
               state_in  = ST_DUMP_RD;
               case (cmd.op)
                  OP_ADD: begin
                     if (!full_ff) state_in = ST_SCAN_RD;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     full_in  = 1'b0;
                  end
                  OP_FULL: begin
                     if (!scr_zero) begin
                        we       = 1'b1;
                        wa       = '0;
                        wd       = scr_box;
                        count_in = CW'(1);
                        full_in  = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (i_ff == count_ff) begin
               state_in = ST_APPEND;
            end else begin
               ra       = AW'(i_ff);
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (boxes_touch(rd, nbox_ff)) begin
               acc_in   = box_union(rd, nbox_ff);
               we       = 1'b1;
               wa       = AW'(i_ff);
               wd       = box_union(rd, nbox_ff);
               j_in     = '0;
               state_in = ST_FOLD_RD;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_FOLD_RD: begin
            if (j_ff == count_ff) begin
               i_in     = '0;
               state_in = ST_DUMP_RD;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CW'(1);
            end else begin
               ra       = AW'(j_ff);
               state_in = ST_FOLD_CHK;
            end
         end
         ST_FOLD_CHK: begin
            if (boxes_touch(acc_ff, rd)) begin
               acc_in   = box_union(acc_ff, rd);
               we       = 1'b1;
               wa       = AW'(i_ff);
               wd       = box_union(acc_ff, rd);
               count_in = count_ff - CW'(1);
               if (i_ff == count_ff - CW'(1)) i_in = j_ff;
               state_in = ST_MOVE_RD;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = ST_FOLD_RD;
            end
         end
         ST_MOVE_RD: begin
            ra       = AW'(count_ff);
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            // last entry fills the freed slot; the accumulator follows if it was last
            we       = 1'b1;
            wa       = AW'(j_ff);
            wd       = (i_ff == j_ff) ? acc_ff : rd;
            state_in = ST_FOLD_RD;
         end
         ST_APPEND: begin
            if (count_ff >= CW'(MAX_RECTS)) begin
               we       = 1'b1;
               wa       = '0;
               wd       = scr_box;
               count_in = CW'(1);
               full_in  = 1'b1;
            end else begin
               we       = 1'b1;
               wa       = AW'(count_ff);
               wd       = nbox_ff;
               count_in = count_ff + CW'(1);
            end
            i_in     = '0;
            state_in = ST_DUMP_RD;
         end
         ST_DUMP_RD: begin
            ra       = AW'(i_ff);
            state_in = (count_ff == '0) ? ST_DUMP_EMPTY : ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            out_valid = 1'b1;
            if (out_take) begin
               i_in     = i_ff + CW'(1);
               state_in = (i_ff + CW'(1) == count_ff) ? ST_IDLE : ST_DUMP_RD;
            end
         end
         ST_DUMP_EMPTY: begin
            out_valid = 1'b1;
            if (out_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign o_status      = status_ff;
   assign o_all_dirty   = full_ff;
   assign o_rect_count  = 5'(count_ff);
   assign o_entry_valid = (state_ff == ST_DUMP_OUT);
   assign o_box         = (state_ff == ST_DUMP_OUT) ? rd : '0;
   assign o_last        = (state_ff == ST_DUMP_EMPTY) || (i_ff + CW'(1) == count_ff);

endmodule

[src/damage_rect_merger_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damage rectangle merger core
// Keeps a bounded list of screen damage rectangles and emits it per request.
// Flow: the front clip stages, the hand-over to the back end, a scan of the
// list, then either a fold pass that checks the other entries and moves the
// last entry into each freed slot, or an append; then one response per entry.
// The back end handles one request at a time; the front can queue the next.
// Reset clears list count and full flag; screen size registers reset to 0.
// ----------------------------------------------------------------------------
module damage_rect_merger_core
   import drm_pkg::*;
#(
   parameter int MAX_RECTS = DEF_MAX_RECTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [15:0]        csr_data,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_action,
   input  logic signed [16:0] req_rect_x,
   input  logic signed [16:0] req_rect_y,
   input  logic signed [17:0] req_rect_width,
   input  logic signed [17:0] req_rect_height,
   input  logic               req_window_active,
   input  logic signed [16:0] req_window_x,
   input  logic signed [16:0] req_window_y,
   input  logic [15:0]        req_window_width,
   input  logic [15:0]        req_window_height,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_status,
   output logic               rsp_all_dirty,
   output logic [4:0]         rsp_rect_count,
   output logic               rsp_entry_valid,
   output logic [15:0]        rsp_out_x,
   output logic [15:0]        rsp_out_y,
   output logic [15:0]        rsp_out_width,
   output logic [15:0]        rsp_out_height,
   output logic               rsp_last
);

   logic [15:0] scr_w_ff, scr_h_ff;
   logic        cmd_valid, cmd_take, out_valid;
   cmd_type     cmd;
   box_type     obox;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= '0;
         scr_h_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == 1'b0) scr_w_ff <= csr_data;
         else                   scr_h_ff <= csr_data;
      end
   end

   drm_front u_front (
      .clock, .reset,
      .req_push (push), .req_full (full),
      .req_action, .req_rect_x, .req_rect_y, .req_rect_width, .req_rect_height,
      .req_window_active, .req_window_x, .req_window_y,
      .req_window_width, .req_window_height,
      .disp_w (scr_w_ff), .disp_h (scr_h_ff),
      .cmd_valid, .cmd, .cmd_take
   );

   drm_back #(.MAX_RECTS(MAX_RECTS)) u_back (
      .clock, .reset,
      .disp_w (scr_w_ff), .disp_h (scr_h_ff),
      .cmd_valid, .cmd, .cmd_take,
      .out_valid, .out_take (pop),
      .o_status (rsp_status), .o_all_dirty (rsp_all_dirty),
      .o_rect_count (rsp_rect_count), .o_entry_valid (rsp_entry_valid),
      .o_box (obox), .o_last (rsp_last)
   );

   assign empty          = !out_valid;
   assign rsp_out_x      = obox.x;
   assign rsp_out_y      = obox.y;
   assign rsp_out_width  = obox.w;
   assign rsp_out_height = obox.h;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_rect_count <= 5'(MAX_RECTS)) else $error("list count overflow");
   a_empty_list: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_entry_valid) |-> (rsp_last && rsp_rect_count == 5'd0))
      else $error("empty list response malformed");
   a_full_one: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_all_dirty && rsp_entry_valid) |-> rsp_rect_count == 5'd1)
      else $error("collapsed list not single");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damage rectangle merger testbench
// Drives add, window add, list reset and full screen requests through the
// request queue, writes the screen size registers between phases and checks
// every list dump entry against a behavioral list predictor or a typed dump.
// ----------------------------------------------------------------------------
module tb_top;
   import drm_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      longint x, y, w, h;
   } area_type;

   typedef struct packed {
      logic        status;
      logic        all_dirty;
      logic [4:0]  rect_count;
      logic        entry_valid;
      logic [15:0] x, y, w, h;
      logic        last;
   } dump_type;

   typedef struct {
      action_type         action;
      logic signed [16:0] rx, ry;
      logic signed [17:0] rw, rh;
      logic               wa;
      logic signed [16:0] wx, wy;
      logic [15:0]        ww, wh;
      bit                 typed;
      dump_type           typed_dump;
   } damage_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [15:0] csr_data = '0;
   logic push = 1'b0;
   logic full;
   logic [1:0] req_action = '0;
   logic signed [16:0] req_rect_x = '0, req_rect_y = '0;
   logic signed [17:0] req_rect_width = '0, req_rect_height = '0;
   logic req_window_active = 1'b0;
   logic signed [16:0] req_window_x = '0, req_window_y = '0;
   logic [15:0] req_window_width = '0, req_window_height = '0;
   logic empty;
   logic pop = 1'b0;
   logic rsp_status, rsp_all_dirty, rsp_entry_valid, rsp_last;
   logic [4:0] rsp_rect_count;
   logic [15:0] rsp_out_x, rsp_out_y, rsp_out_width, rsp_out_height;

   damage_rect_merger_core u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .push(push), .full(full),
      .req_action(req_action), .req_rect_x(req_rect_x), .req_rect_y(req_rect_y),
      .req_rect_width(req_rect_width), .req_rect_height(req_rect_height),
      .req_window_active(req_window_active), .req_window_x(req_window_x),
      .req_window_y(req_window_y), .req_window_width(req_window_width),
      .req_window_height(req_window_height),
      .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_all_dirty(rsp_all_dirty),
      .rsp_rect_count(rsp_rect_count), .rsp_entry_valid(rsp_entry_valid),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_width(rsp_out_width),
      .rsp_out_height(rsp_out_height), .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // merge list mirror
   area_type list_area[LIST_DEPTH];
   int     list_len = 0;
   bit     list_full = 1'b0;
   longint screen_w = 0, screen_h = 0;

   dump_type dump_q[$];
   damage_req_type directed_q[$];
   int     err_count = 0;
   bit     hold_req = 1'b0;
   bit     no_idle = 1'b0;
   int     stall_cnt = 0;

   function automatic bit clip_area(longint x, longint y, longint w, longint h,
                                    longint cr, longint cb, output area_type res);
      longint l, t, r, b;
      res = '{0, 0, 0, 0};
      if (w <= 0 || h <= 0) return 1'b0;
      l = x; t = y; r = x + w; b = y + h;
      if (l < 0) l = 0;
      if (t < 0) t = 0;
      if (r > cr) r = cr;
      if (b > cb) b = cb;
      if (r <= l || b <= t) return 1'b0;
      res = '{l, t, r - l, b - t};
      return 1'b1;
   endfunction

   function automatic bit areas_touch(area_type a, area_type b);
      return a.x <= b.x + b.w && b.x <= a.x + a.w &&
             a.y <= b.y + b.h && b.y <= a.y + a.h;
   endfunction

   function automatic area_type area_union(area_type a, area_type b);
      area_type u;
      longint r, bt;
      r  = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
      bt = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
      u.x = (a.x < b.x) ? a.x : b.x;
      u.y = (a.y < b.y) ? a.y : b.y;
      u.w = r - u.x;
      u.h = bt - u.y;
      return u;
   endfunction

   task automatic collapse_full();
      if (screen_w == 0 || screen_h == 0) return;
      list_len = 1;
      list_full = 1'b1;
      list_area[0] = '{0, 0, screen_w, screen_h};
   endtask

   task automatic merge_add(longint x, longint y, longint w, longint h,
                            output bit status);
      area_type c;
      int i, j;
      status = 1'b0;
      if (screen_w == 0 || screen_h == 0) begin
         status = 1'b1;
         return;
      end
      if (list_full) return;
      if (!clip_area(x, y, w, h, screen_w, screen_h, c)) return;
      for (i = 0; i < list_len; i++) begin
         if (!areas_touch(list_area[i], c)) continue;
         list_area[i] = area_union(list_area[i], c);
         j = 0;
         while (j < list_len) begin
            if (j == i || !areas_touch(list_area[i], list_area[j])) begin
               j++;
            end else begin
               list_area[i] = area_union(list_area[i], list_area[j]);
               list_area[j] = list_area[list_len - 1];
               list_len--;
               if (i == list_len) i = j;
            end
         end
         return;
      end
      if (list_len >= LIST_DEPTH) collapse_full();
      else list_area[list_len++] = c;
   endtask

   task automatic apply_damage(damage_req_type r);
      bit       status;
      area_type loc;
      dump_type d;
      status = 1'b0;
      case (r.action)
         ACT_ADD_SCREEN: begin
            merge_add(longint'(r.rx), longint'(r.ry), longint'(r.rw),
                      longint'(r.rh), status);
         end
         ACT_ADD_WINDOW: begin
            if (!r.wa) status = 1'b1;
            else if (clip_area(longint'(r.rx), longint'(r.ry), longint'(r.rw),
                               longint'(r.rh), longint'(r.ww), longint'(r.wh), loc))
               merge_add(longint'(r.wx) + loc.x, longint'(r.wy) + loc.y,
                         loc.w, loc.h, status);
         end
         ACT_RESET_LIST: begin
            list_len = 0;
            list_full = 1'b0;
         end
         default: collapse_full();
      endcase
      if (r.typed) begin
         dump_q.push_back(r.typed_dump);
         return;
      end
      if (list_len == 0) begin
         d = '0;
         d.status = status;
         d.all_dirty = list_full;
         d.last = 1'b1;
         dump_q.push_back(d);
      end
      for (int k = 0; k < list_len; k++) begin
         d.status = status;
         d.all_dirty = list_full;
         d.rect_count = 5'(list_len);
         d.entry_valid = 1'b1;
         d.x = 16'(list_area[k].x);
         d.y = 16'(list_area[k].y);
         d.w = 16'(list_area[k].w);
         d.h = 16'(list_area[k].h);
         d.last = (k + 1 == list_len);
         dump_q.push_back(d);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_csr(logic idx, logic [15:0] val);
      wait (dump_q.size() == 0);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == 1'b0) screen_w = longint'(val);
      else screen_h = longint'(val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_damage(damage_req_type r, int gap);
      if (gap > 0) begin
         @(negedge clock);
         push = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_action = r.action;
      req_rect_x = r.rx;
      req_rect_y = r.ry;
      req_rect_width = r.rw;
      req_rect_height = r.rh;
      req_window_active = r.wa;
      req_window_x = r.wx;
      req_window_y = r.wy;
      req_window_width = r.ww;
      req_window_height = r.wh;
      push = 1'b1;
      do @(posedge clock); while (full);
      apply_damage(r);
   endtask

   task automatic idle_push();
      @(negedge clock);
      push = 1'b0;
   endtask

   function automatic damage_req_type mk_req(action_type a, int rx, int ry, int rw, int rh,
                                             bit wa, int wx, int wy, int ww, int wh);
      damage_req_type r;
      r.action = a;
      r.rx = 17'(rx); r.ry = 17'(ry); r.rw = 18'(rw); r.rh = 18'(rh);
      r.wa = wa; r.wx = 17'(wx); r.wy = 17'(wy); r.ww = 16'(ww); r.wh = 16'(wh);
      r.typed = 1'b0;
      r.typed_dump = '0;
      return r;
   endfunction

   function automatic damage_req_type mk_typed(damage_req_type r, dump_type d);
      r.typed = 1'b1;
      r.typed_dump = d;
      return r;
   endfunction

   function automatic damage_req_type rand_req();
      damage_req_type r;
      int a;
      int sw, sh;
      sw = (screen_w > 0) ? int'(screen_w) : 64;
      sh = (screen_h > 0) ? int'(screen_h) : 64;
      a = $urandom_range(0, 99);
      r = mk_req(ACT_ADD_SCREEN, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0);
      if (a < 50) r.action = ACT_ADD_SCREEN;
      else if (a < 88) r.action = ACT_ADD_WINDOW;
      else if (a < 96) r.action = ACT_RESET_LIST;
      else r.action = ACT_MARK_ALL;
      if ($urandom_range(0, 9) == 0) begin
         r.rx = 17'($urandom); r.ry = 17'($urandom);
         r.rw = 18'($urandom); r.rh = 18'($urandom);
         r.wa = 1'($urandom);
         r.wx = 17'($urandom); r.wy = 17'($urandom);
         r.ww = 16'($urandom); r.wh = 16'($urandom);
      end else begin
         r.rx = 17'(int'($urandom_range(0, sw + 20)) - 10);
         r.ry = 17'(int'($urandom_range(0, sh + 20)) - 10);
         r.rw = 18'(int'($urandom_range(0, 40)) - 2);
         r.rh = 18'(int'($urandom_range(0, 40)) - 2);
         r.wa = ($urandom_range(0, 19) != 0);
         r.wx = 17'(int'($urandom_range(0, sw + 40)) - 20);
         r.wy = 17'(int'($urandom_range(0, sh + 40)) - 20);
         r.ww = 16'($urandom_range(0, 300));
         r.wh = 16'($urandom_range(0, 300));
      end
      return r;
   endfunction

   task automatic run_random(int count, bit pressure);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
         if (pressure && n == 20) hold_req = 1'b1;
         if (pressure && n == 60) begin
            idle_push();
            wait (dump_q.size() == 0);
         end
         send_damage(rand_req(), pick_gap());
      end
      no_idle = 1'b0;
      idle_push();
   endtask

   // receiver side
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               pop = 1'b1;
            end else begin
               pop = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      dump_type e;
      if (!reset && pop && !empty) begin
         if (dump_q.size() == 0) begin
            $error("unexpected result: x %0d y %0d", rsp_out_x, rsp_out_y);
            err_count++;
         end else begin
            e = dump_q.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_status);
               err_count++;
            end
            if (rsp_all_dirty !== e.all_dirty) begin
               $error("all_dirty: expected %0d actual %0d", e.all_dirty,
                      rsp_all_dirty);
               err_count++;
            end
            if (rsp_rect_count !== e.rect_count) begin
               $error("rect_count: expected %0d actual %0d", e.rect_count,
                      rsp_rect_count);
               err_count++;
            end
            if (rsp_entry_valid !== e.entry_valid) begin
               $error("entry_valid: expected %0d actual %0d", e.entry_valid,
                      rsp_entry_valid);
               err_count++;
            end
            if (rsp_out_x !== e.x) begin
               $error("out_x: expected %0d actual %0d", e.x, rsp_out_x);
               err_count++;
            end
            if (rsp_out_y !== e.y) begin
               $error("out_y: expected %0d actual %0d", e.y, rsp_out_y);
               err_count++;
            end
            if (rsp_out_width !== e.w) begin
               $error("out_width: expected %0d actual %0d", e.w, rsp_out_width);
               err_count++;
            end
            if (rsp_out_height !== e.h) begin
               $error("out_height: expected %0d actual %0d", e.h, rsp_out_height);
               err_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d actual %0d", e.last, rsp_last);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready) || reset)
         stall_cnt <= 0;
      else
         stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      dump_type empty_ok, empty_bad;
      empty_ok = '0;
      empty_ok.last = 1'b1;
      empty_bad = empty_ok;
      empty_bad.status = 1'b1;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero screen size after reset
      directed_q = {};
      directed_q.push_back(mk_typed(mk_req(ACT_ADD_SCREEN, 0, 0, 10, 10, 1, 0, 0, 0, 0),
                                    empty_bad));
      directed_q.push_back(mk_typed(mk_req(ACT_ADD_WINDOW, 0, 0, 10, 10, 1, 0, 0, 50, 50),
                                    empty_bad));
      directed_q.push_back(mk_typed(mk_req(ACT_MARK_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    empty_ok));
      directed_q.push_back(mk_typed(mk_req(ACT_RESET_LIST, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    empty_ok));
      foreach (directed_q[i]) send_damage(directed_q[i], 0);
      idle_push();

      write_csr(1'b0, 16'd640);
      write_csr(1'b1, 16'd480);

      directed_q = {};
      directed_q.push_back(mk_typed(mk_req(ACT_MARK_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    '{1'b0, 1'b1, 5'd1, 1'b1, 16'd0, 16'd0,
                                      16'd640, 16'd480, 1'b1}));
      directed_q.push_back(mk_req(ACT_ADD_SCREEN, 5, 5, 10, 10, 0, 0, 0, 0, 0));
      directed_q.push_back(mk_typed(mk_req(ACT_RESET_LIST, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    empty_ok));
      directed_q.push_back(mk_typed(mk_req(ACT_ADD_WINDOW, 0, 0, 10, 10, 0, 0, 0, 50, 50),
                                    empty_bad));
      directed_q.push_back(mk_req(ACT_ADD_SCREEN, -65536, -65536, 131071, 131071,
                                  0, 0, 0, 0, 0));
      directed_q.push_back(mk_req(ACT_RESET_LIST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(mk_req(ACT_ADD_SCREEN, 10, 10, -131072, 5, 0, 0, 0, 0, 0));
      directed_q.push_back(mk_req(ACT_ADD_SCREEN, 10, 10, 5, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(mk_req(ACT_ADD_SCREEN, 65535, 65535, 10, 10, 0, 0, 0, 0, 0));
      directed_q.push_back(mk_req(ACT_ADD_SCREEN, 0, 0, 10, 10, 0, 0, 0, 0, 0));
      directed_q.push_back(mk_req(ACT_ADD_SCREEN, 10, 0, 5, 5, 0, 0, 0, 0, 0));
      directed_q.push_back(mk_req(ACT_ADD_SCREEN, 100, 100, 10, 10, 0, 0, 0, 0, 0));
      directed_q.push_back(mk_req(ACT_ADD_SCREEN, 50, 50, 50, 50, 0, 0, 0, 0, 0));
      directed_q.push_back(mk_req(ACT_ADD_WINDOW, -5, -5, 131071, 131071, 1,
                                  -65536, -65536, 65535, 65535));
      directed_q.push_back(mk_req(ACT_ADD_WINDOW, 0, 0, 20, 20, 1, 65535, 65535, 100, 100));
      directed_q.push_back(mk_req(ACT_ADD_WINDOW, 2, 3, 20, 20, 1, 300, 200, 10, 10));
      directed_q.push_back(mk_req(ACT_ADD_WINDOW, 0, 0, 20, 20, 1, 300, 200, 0, 0));
      foreach (directed_q[i]) send_damage(directed_q[i], $urandom_range(0, 2));
      idle_push();

      run_random(110, 1'b1);

      write_csr(1'b0, 16'hFFFF);
      write_csr(1'b1, 16'hFFFF);
      run_random(60, 1'b0);

      write_csr(1'b0, 16'd1);
      write_csr(1'b1, 16'd1);
      run_random(30, 1'b0);

      write_csr(1'b0, 16'd0);
      write_csr(1'b1, 16'd200);
      run_random(15, 1'b0);

      wait (dump_q.size() == 0);
      repeat (200) @(posedge clock);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
src/drm_pkg.sv
src/drm_ram.sv
src/drm_front.sv
src/drm_back.sv
src/damage_rect_merger_core.sv
bench/tb_top.sv
